>>> hw/rtl/bldf_pkg.sv
// ----------------------------------------------------------------------------
// bldf_pkg: shared types and constants for the LED digit frame block
// Field widths, conversion constants and the front FSM state type.
// ----------------------------------------------------------------------------
package bldf_pkg;

  localparam int unsigned DIGIT_COUNT_DEF = 8;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned SEG_W   = 8;

  // blank code; never carries the point bit
  localparam logic [SEG_W-1:0] BLANK_CODE = 8'd15;

  // x / 10 == (x * 0xCCCCCCCD) >> 35, exact for all 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_CONV,
    FRONT_PUSH
  } front_state_e;

endpackage

>>> hw/rtl/bldf_front.sv
// ----------------------------------------------------------------------------
// bldf_front: value intake and decimal conversion
// Takes one value, peels one decimal digit per cycle, pushes the frame record.
// ----------------------------------------------------------------------------
module bldf_front #(
  parameter int unsigned DIGIT_COUNT = bldf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [bldf_pkg::VALUE_W-1:0]           value_i,
  input  logic                                   point_on_i,
  output logic                                   push_valid_o,
  input  logic                                   push_ready_i,
  output logic [DIGIT_COUNT*bldf_pkg::SEG_W:0]   push_data_o
);
  import bldf_pkg::*;

  localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned PROD_W = 2 * VALUE_W;

  front_state_e state_q, state_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_W-1:0] quot_q;
  logic               point_q;
  logic [SEG_W-1:0]   codes_q [DIGIT_COUNT];

  logic               accept;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot_next;
  logic [VALUE_W-1:0] rem_full;
  logic [SEG_W-1:0]   code;
  logic               cnt_last;

  // one reciprocal multiply per digit; times ten by shift and add
  always_comb begin
    prod      = PROD_W'(quot_q) * PROD_W'(RECIP_10);
    quot_next = VALUE_W'(prod >> RECIP_SHIFT);
    rem_full  = quot_q - ((quot_next << 3) + (quot_next << 1));
    if (quot_q != '0) begin
      code = {point_q, 3'b000, rem_full[3:0]};
    end else begin
      code = BLANK_CODE;
    end
  end

  assign cnt_last = (cnt_q == IDX_W'(DIGIT_COUNT - 1));

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      FRONT_IDLE: begin
        in_ready_o = 1'b1;
      end
      FRONT_CONV: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_last) begin
          state_d = FRONT_PUSH;
        end
      end
      FRONT_PUSH: begin
        push_valid_o = 1'b1;
        in_ready_o   = push_ready_i;
        if (push_ready_i) begin
          state_d = FRONT_IDLE;
        end
      end
      default: begin
        state_d = FRONT_IDLE;
      end
    endcase
    accept = in_valid_i & in_ready_o;
    if (accept) begin
      state_d = FRONT_CONV;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      quot_q  <= value_i;
      point_q <= point_on_i;
    end else if (state_q == FRONT_CONV) begin
      quot_q         <= quot_next;
      codes_q[cnt_q] <= code;
    end
  end

  // record: overflow on top, digit codes from position 1 upward
  always_comb begin
    push_data_o[DIGIT_COUNT*SEG_W] = (quot_q != '0);
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      push_data_o[i*SEG_W +: SEG_W] = codes_q[i];
    end
  end

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == FRONT_CONV)
    else $error("front did not start conversion after a transfer");

  a_push_after_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FRONT_PUSH |-> $past(state_q) == FRONT_CONV || $past(state_q) == FRONT_PUSH)
    else $error("front reached push without converting");

endmodule

>>> hw/rtl/bldf_queue.sv
// ----------------------------------------------------------------------------
// bldf_queue: short record queue between front and back
// Two-entry register FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
module bldf_queue #(
  parameter int unsigned WIDTH = 65
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import bldf_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push_fire, pop_fire;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push_fire    = push_valid_i & push_ready_o;
  assign pop_fire     = pop_valid_o & pop_ready_i;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_fire) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_fire && !pop_fire) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_tracks_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_fire && !pop_fire |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue count lost a push");

endmodule

>>> hw/rtl/bldf_back.sv
// ----------------------------------------------------------------------------
// bldf_back: digit write sequencer
// Pops one frame record, sends one digit write per cycle unless stalled, lowest first.
// ----------------------------------------------------------------------------
module bldf_back #(
  parameter int unsigned DIGIT_COUNT = bldf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 pop_valid_i,
  output logic                                 pop_ready_o,
  input  logic [DIGIT_COUNT*bldf_pkg::SEG_W:0] pop_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bldf_pkg::ADDR_W-1:0]          digit_address_o,
  output logic [bldf_pkg::SEG_W-1:0]           segment_code_o,
  output logic                                 overflow_o,
  output logic                                 last_o
);
  import bldf_pkg::*;

  localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic               busy_q, busy_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [SEG_W-1:0]   codes_q [DIGIT_COUNT];
  logic               ovf_rec_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [SEG_W-1:0]   code_q;
  logic               ovf_q;
  logic               last_q;

  logic load_out, is_last, pop;

  assign is_last     = (cnt_q == IDX_W'(DIGIT_COUNT - 1));
  assign load_out    = busy_q & (~out_valid_q | out_ready_i);
  // take the next record as the current one sends its final write
  assign pop         = pop_valid_i & (~busy_q | (load_out & is_last));
  assign pop_ready_o = ~busy_q | (load_out & is_last);

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    out_valid_d = load_out | (out_valid_q & ~out_ready_i);
    if (load_out) begin
      cnt_d = cnt_q + IDX_W'(1);
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
    if (pop) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ovf_rec_q <= pop_data_i[DIGIT_COUNT*SEG_W];
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        codes_q[i] <= pop_data_i[i*SEG_W +: SEG_W];
      end
    end
    if (load_out) begin
      addr_q <= ADDR_W'(cnt_q) + ADDR_W'(1);
      code_q <= codes_q[cnt_q];
      ovf_q  <= ovf_rec_q;
      last_q <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digit_address_o = addr_q;
  assign segment_code_o  = code_q;
  assign overflow_o      = ovf_q;
  assign last_o          = last_q;

  a_last_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> digit_address_o == ADDR_W'(DIGIT_COUNT))
    else $error("last flag not on the most significant position");

endmodule

>>> hw/rtl/binary_to_led_digit_frames.sv
// ----------------------------------------------------------------------------
// binary_to_led_digit_frames: binary value to decimal digit register writes
// A value's first digit write leaves after the front's conversion, the queue
// and the back's output register. The input takes a new value only once the
// front has pushed the last record, so the one-digit-per-cycle divide-by-ten
// loop in the front sets the input rate; writes leave at one per cycle while
// out_ready_i is high, DIGIT_COUNT per value.
// Reset: asynchronous, active low; clears all handshake state, sets point_on.
// ----------------------------------------------------------------------------
//
// Structure:
//   front  - takes a value, runs DIGIT_COUNT divide-by-ten steps (reciprocal
//            multiply), builds the code for each position and the overflow
//            flag (quotient left over after the last position).
//   queue  - two frame records, so the front can convert the next value while
//            the back still sends the writes of the current one.
//   back   - sends one digit write per cycle while out_ready_i is high, from an
//            output register, address 1 (lowest digit) up to DIGIT_COUNT, last on top.
//
// Codes: significant digit = value 0..9 with bit 7 set when point_on was set
// at the input transfer; positions past the value's length, and all positions
// of a zero value, get the plain blank code 15.
module binary_to_led_digit_frames #(
  parameter int unsigned DIGIT_COUNT = bldf_pkg::DIGIT_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: point_on register
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // value input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bldf_pkg::VALUE_W-1:0]  value_i,
  // digit writes
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bldf_pkg::ADDR_W-1:0]   digit_address_o,
  output logic [bldf_pkg::SEG_W-1:0]    segment_code_o,
  output logic                          overflow_o,
  output logic                          last_o
);
  import bldf_pkg::*;

  localparam int unsigned REC_W = DIGIT_COUNT * SEG_W + 1;

  logic             point_on_q;

  logic             push_valid, push_ready;
  logic [REC_W-1:0] push_data;
  logic             pop_valid, pop_ready;
  logic [REC_W-1:0] pop_data;

  // point_on resets to 1; write it only while idle (the block does not enforce this)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_on_q <= 1'b1;
    end else if (cfg_we_i) begin
      point_on_q <= cfg_wdata_i;
    end
  end

  bldf_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .point_on_i   (point_on_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  bldf_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  bldf_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_data_i      (pop_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .digit_address_o (digit_address_o),
    .segment_code_o  (segment_code_o),
    .overflow_o      (overflow_o),
    .last_o          (last_o)
  );

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_to_led_digit_frames
// Feeds 32-bit values, predicts the eight digit writes of each one (digit or
// blank code, point bit, overflow, last flag) and checks every write in order.
// ----------------------------------------------------------------------------
module tb;

  import bldf_pkg::*;

  localparam int unsigned DIGITS      = DIGIT_COUNT_DEF;
  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;
  localparam int unsigned RADIX       = 10;
  // cycles allowed for the block to empty out at a phase boundary
  localparam int unsigned DRAIN_LIMIT = 20000;
  // idle time after the last drain, before the final check
  localparam int unsigned SETTLE_CYCLES = 16;

  // one digit register write, as it leaves the block
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SEG_W-1:0]  code;
    logic              ovf;
    logic              last;
  } digit_write_t;

  // --------------------------------------------------------------------------
  // Expected digit writes: built per accepted value, consumed per write
  // --------------------------------------------------------------------------
  class digit_write_checker;
    digit_write_t expected_writes[$];
    int unsigned  errors;

    function new();
      errors = 0;
    endfunction

    // one line per mismatch, and a running count
    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // decimal conversion of one value into its eight writes, low digit first
    function void note_value(input logic [VALUE_W-1:0] value, input bit point);
      logic [VALUE_W-1:0] rest;
      logic [SEG_W-1:0]   codes[DIGITS];
      logic [3:0]         digit;
      digit_write_t       w;
      rest = value;
      for (int k = 0; k < DIGITS; k++) begin
        if (rest != 0) begin
          digit = 4'(rest % RADIX);
          rest  = rest / RADIX;
          codes[k] = SEG_W'(digit) | (point ? POINT_BIT : '0);
        end else begin
          // past the value's length, or a zero value: plain blank
          codes[k] = BLANK_CODE;
        end
      end
      // anything left above the top position means the value did not fit
      for (int k = 0; k < DIGITS; k++) begin
        w.addr = ADDR_W'(k + 1);
        w.code = codes[k];
        w.ovf  = (rest != 0);
        w.last = (k == DIGITS - 1);
        expected_writes.push_back(w);
      end
    endfunction

    task check_write(input logic [ADDR_W-1:0] addr, input logic [SEG_W-1:0] code,
                     input logic ovf, input logic last);
      digit_write_t w;
      if (expected_writes.size() == 0) begin
        report($sformatf("write to address %0d with no value pending", addr));
        return;
      end
      w = expected_writes.pop_front();
      if (addr !== w.addr)
        report($sformatf("digit_address %0d, expected %0d", addr, w.addr));
      if (code !== w.code)
        report($sformatf("segment_code %0d at address %0d, expected %0d",
                         code, w.addr, w.code));
      if (ovf !== w.ovf)
        report($sformatf("overflow %b at address %0d, expected %b", ovf, w.addr, w.ovf));
      if (last !== w.last)
        report($sformatf("last %b at address %0d, expected %b", last, w.addr, w.last));
    endtask

    function int unsigned pending();
      return expected_writes.size();
    endfunction

    task close();
      if (expected_writes.size() != 0)
        report($sformatf("%0d digit writes never arrived", expected_writes.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input known from time zero
  // --------------------------------------------------------------------------
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [VALUE_W-1:0] value_i     = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ADDR_W-1:0]  digit_address_o;
  logic [SEG_W-1:0]   segment_code_o;
  logic               overflow_o;
  logic               last_o;

  digit_write_checker board = new();

  // bench copy of the point_on register, taken at each value transfer
  bit          point_on   = 1'b1;
  // random idling on both channels; switched off for the closing phase
  bit          idling_en  = 1'b1;
  int unsigned stall_left = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  binary_to_led_digit_frames u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .digit_address_o (digit_address_o),
    .segment_code_o  (segment_code_o),
    .overflow_o      (overflow_o),
    .last_o          (last_o)
  );

  // --------------------------------------------------------------------------
  // Write side: ready drops in random bursts, changed at negedge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (idling_en && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 16);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // every write transfer is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_write(digit_address_o, segment_code_o, overflow_o, last_o);
  end

  // --------------------------------------------------------------------------
  // Value side
  // --------------------------------------------------------------------------
  // Valid stays high from one transfer into the next unless a gap is drawn,
  // so it is never lowered and raised within one time step.
  task automatic send_value(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    if (idling_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_value(value, point_on);
  endtask

  // stop sending and wait for every pending write; the block is idle after
  task automatic wait_drained();
    int unsigned spent = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0 && spent < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spent++;
    end
  endtask

  // only called with the block idle
  task automatic write_point(input bit point);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= point;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    point_on = point;
  endtask

  // mostly values of a random decimal length, so every digit count and the
  // overflow boundary are hit often; some raw 32-bit, zero and near-top values
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned      ndig;
    longint unsigned  lo;
    longint unsigned  hi;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return '0;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: begin
        ndig = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * RADIX;
        hi = (ndig == 10) ? 64'hFFFF_FFFF : lo * RADIX - 1;
        return VALUE_W'($urandom_range(32'(hi), 32'(lo)));
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------
  initial begin
    logic [VALUE_W-1:0] corners[$];
    // zero, single digits, several length boundaries, interior zeros,
    // the largest value that fits and the smallest that does not
    corners = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd90, 32'd100, 32'd1000000,
                32'd10203040, 32'd12345678, 32'd99999999, 32'd100000000,
                32'd100000001, 32'd999999999, 32'h8000_0000, 32'hAAAA_AAAA,
                32'h5555_5555, 32'hFFFF_FFFF};

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_point(1'b1);
    foreach (corners[i]) send_value(corners[i]);
    wait_drained();

    // some of the corners without the point bit
    write_point(1'b0);
    send_value(32'd0);
    send_value(32'd1000);
    send_value(32'd100000000);
    send_value(32'hFFFF_FFFF);

    // random phases alternate point_on; the last one runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      if (ph == 3) idling_en = 1'b0;
      write_point(ph[0]);
      for (int i = 0; i < 38; i++) begin
        // hold off once until the block has sent everything
        if (ph == 1 && i == 19) wait_drained();
        send_value(pick_value());
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    board.close();
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bldf_pkg.sv
hw/rtl/bldf_front.sv
hw/rtl/bldf_queue.sv
hw/rtl/bldf_back.sv
hw/rtl/binary_to_led_digit_frames.sv
tb/sv/tb.sv
